// ===== hw/rtl/fqrr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqrr_pkg: shared types for the linked-list ready queue
// Command codes, status codes and sequencer states.
// ----------------------------------------------------------------------------
package fqrr_pkg;

	localparam int CMD_W = 3;
	localparam int STATUS_W = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_ENQ    = 3'd0,
		CMD_DEQ    = 3'd1,
		CMD_REMOVE = 3'd2,
		CMD_PEEK   = 3'd3,
		CMD_START  = 3'd4,
		CMD_NEXT   = 3'd5,
		CMD_EXISTS = 3'd6,
		CMD_NOP    = 3'd7
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOCURSOR = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_WALK,
		S_DONE
	} state_t;

endpackage

// ===== hw/rtl/fqrr_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqrr_mem: entry and link storage
// Two simple dual-port synchronous memories (separate write and read addresses),
// one write and one read a cycle, with registered read data.
// ----------------------------------------------------------------------------
module fqrr_mem #(
	parameter int DEPTH   = 16,
	parameter int ENTRY_W = 32,
	parameter int SLOT_W  = 4
) (
	input  logic               clk,
	input  logic [SLOT_W-1:0]  rd_addr,
	output logic [ENTRY_W-1:0] rd_entry,
	output logic [SLOT_W-1:0]  rd_link,
	input  logic               we_entry,
	input  logic [SLOT_W-1:0]  wa_entry,
	input  logic [ENTRY_W-1:0] wd_entry,
	input  logic               we_link,
	input  logic [SLOT_W-1:0]  wa_link,
	input  logic [SLOT_W-1:0]  wd_link
);

	logic [ENTRY_W-1:0] entry_mem [DEPTH];
	logic [SLOT_W-1:0]  link_mem  [DEPTH];

	always_ff @(posedge clk) begin
		if (we_entry) entry_mem[wa_entry] <= wd_entry;
		rd_entry <= entry_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (we_link) link_mem[wa_link] <= wd_link;
		rd_link <= link_mem[rd_addr];
	end

endmodule

// ===== hw/rtl/fifo_queue_with_removal_and_rr_cursor_unit.sv =====
`timescale 1ns / 1ps
// Sequence per item: accepted in S_IDLE, then S_READ; dequeue, peek and cursor next then
//   read in S_WALK, while enqueue, start, no-op and any command refused on status go straight
//   to S_DONE; remove and exists alternate S_READ and S_WALK per entry walked, up to DEPTH,
//   since each step waits on one read of the entry/link memory. The result is offered in S_DONE.
// Throughput: one item at a time; the next item is taken when the result leaves.
// Reset: asynchronous, clears the free map, pointers, count and cursor. The
//   memories are not cleared; only linked slots are ever read.
// ----------------------------------------------------------------------------
// fifo_queue_with_removal_and_rr_cursor_unit: linked-list ready queue
// FIFO with keyed removal, existence search and a round-robin cursor.
// ----------------------------------------------------------------------------
module fifo_queue_with_removal_and_rr_cursor_unit #(
	parameter int DEPTH   = 16,
	parameter int ENTRY_W = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // cmd[2:0], entry_value[34:3], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata   // status[1:0], data_out[33:2], entry_count[38:34],
	                              // cursor_active[39], cursor_at_head[40], zero pad
);
	import fqrr_pkg::*;

	localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);

	state_t state_q, state_n;

	cmd_t               cmd_q;
	logic [ENTRY_W-1:0] key_q;
	logic [DEPTH-1:0]   free_q;
	logic [SLOT_W-1:0]  head_q, tail_q, cur_q, walk_q, prev_q;
	logic               cur_valid_q, has_prev_q, found_q;
	logic [CNT_W-1:0]   count_q, steps_q;
	logic [1:0]         status_q;
	logic [31:0]        data_q;

	logic [SLOT_W-1:0]  rd_addr;
	logic [ENTRY_W-1:0] rd_entry;
	logic [SLOT_W-1:0]  rd_link;
	logic               we_entry, we_link;
	logic [SLOT_W-1:0]  wa_entry, wa_link, wd_link;

	fqrr_mem #(.DEPTH(DEPTH), .ENTRY_W(ENTRY_W), .SLOT_W(SLOT_W)) u_mem (
		.clk(clk), .rd_addr(rd_addr), .rd_entry(rd_entry), .rd_link(rd_link),
		.we_entry(we_entry), .wa_entry(wa_entry), .wd_entry(key_q),
		.we_link(we_link), .wa_link(wa_link), .wd_link(wd_link)
	);

	// Lowest free slot.
	logic [SLOT_W-1:0] free_slot;
	always_comb begin
		free_slot = '0;
		for (int i = DEPTH - 1; i >= 0; i--)
			if (free_q[i]) free_slot = SLOT_W'(i);
	end

	logic full, empty, is_match, cmd_walks;
	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign is_match = (rd_entry == key_q);
	assign cmd_walks = (cmd_q == CMD_REMOVE) || (cmd_q == CMD_EXISTS);

	always_comb begin
		state_n = state_q;
		case (state_q)
			S_IDLE: if (s_tvalid) state_n = S_READ;
			S_READ: begin
				if ((cmd_q == CMD_DEQ || cmd_q == CMD_PEEK) && !empty) state_n = S_WALK;
				else if (cmd_q == CMD_NEXT && cur_valid_q) state_n = S_WALK;
				else if (cmd_walks && !empty) state_n = S_WALK;
				else state_n = S_DONE;
			end
			S_WALK: begin
				if (!cmd_walks) state_n = S_DONE;
				else if (is_match || steps_q == CNT_W'(1)) state_n = S_DONE;
				else state_n = S_READ;
			end
			S_DONE: if (m_tready) state_n = S_IDLE;
			default: state_n = S_IDLE;
		endcase
	end

	// Memory address: the slot being read this step.
	always_comb begin
		rd_addr = walk_q;
		if (state_q == S_READ && steps_q == count_q) begin
			case (cmd_q)
				CMD_NEXT: rd_addr = cur_q;
				default:  rd_addr = head_q;
			endcase
		end
	end

	always_comb begin
		we_entry = (state_q == S_READ) && (cmd_q == CMD_ENQ) && !full;
		wa_entry = free_slot;
		we_link  = 1'b0;
		wa_link  = tail_q;
		wd_link  = free_slot;
		if (state_q == S_READ && cmd_q == CMD_ENQ && !full && !empty) we_link = 1'b1;
		if (state_q == S_WALK && cmd_q == CMD_REMOVE && is_match && has_prev_q
			&& walk_q != tail_q) begin
			we_link = 1'b1;
			wa_link = prev_q;
			wd_link = rd_link;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q <= '1; head_q <= '0; tail_q <= '0; cur_q <= '0;
			cur_valid_q <= 1'b0; count_q <= '0;
		end else if (state_q == S_READ) begin
			case (cmd_q)
				CMD_ENQ: if (!full) begin
					free_q[free_slot] <= 1'b0;
					if (empty) head_q <= free_slot;
					tail_q <= free_slot;
					count_q <= count_q + CNT_W'(1);
				end
				CMD_START: if (!empty) begin
					cur_q <= head_q;
					cur_valid_q <= 1'b1;
				end
				CMD_EXISTS: if (!empty && steps_q == count_q) begin
					cur_q <= head_q;
					cur_valid_q <= 1'b1;
				end
				default: ;
			endcase
		end else if (state_q == S_WALK) begin
			case (cmd_q)
				CMD_NEXT: cur_q <= (cur_q == tail_q) ? head_q : rd_link;
				CMD_EXISTS: cur_q <= (walk_q == tail_q) ? head_q : rd_link;
				CMD_DEQ, CMD_REMOVE: if (cmd_q == CMD_DEQ || is_match) begin
					if (!has_prev_q && walk_q != tail_q) head_q <= rd_link;
					if (has_prev_q && walk_q == tail_q) tail_q <= prev_q;
					if (cur_valid_q && cur_q == walk_q) begin
						if (walk_q == tail_q) cur_valid_q <= 1'b0;
						else cur_q <= rd_link;
					end
					if (count_q == CNT_W'(1)) cur_valid_q <= 1'b0;
					free_q[walk_q] <= 1'b1;
					count_q <= count_q - CNT_W'(1);
				end
				default: ;
			endcase
		end
	end

	// Walk bookkeeping and the result.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_tvalid) begin
			cmd_q <= cmd_t'(s_tdata[2:0]);
			key_q <= ENTRY_W'(s_tdata[34:3]);
			steps_q <= count_q;
			has_prev_q <= 1'b0;
			found_q <= 1'b0;
			status_q <= ST_OK;
			data_q <= '0;
		end else if (state_q == S_READ) begin
			walk_q <= rd_addr;
			case (cmd_q)
				CMD_ENQ:    if (full) status_q <= ST_FULL;
				CMD_NEXT:   if (!cur_valid_q) status_q <= ST_NOCURSOR;
				CMD_START, CMD_DEQ, CMD_PEEK, CMD_REMOVE, CMD_EXISTS:
					if (empty) status_q <= ST_EMPTY;
				default: ;
			endcase
		end else if (state_q == S_WALK) begin
			if (cmd_walks) begin
				if (is_match) found_q <= 1'b1;
				else begin
					prev_q <= walk_q;
					has_prev_q <= 1'b1;
					walk_q <= rd_link;
					steps_q <= steps_q - CNT_W'(1);
				end
				if (!is_match && steps_q == CNT_W'(1)) status_q <= ST_EMPTY;
			end else begin
				data_q <= 32'(rd_entry);
			end
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = (state_q == S_DONE);
	assign m_tdata  = {7'd0, cur_valid_q && cur_q == head_q, cur_valid_q,
		5'(count_q), data_q, status_q};

	ap_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count exceeds depth");
	ap_empty_no_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && count_q == '0) |-> !cur_valid_q)
		else $error("cursor active on empty queue");
	ap_free_match: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> ($countones(free_q) + 32'(count_q) == DEPTH))
		else $error("free map disagrees with count");
	ap_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && found_q) |-> status_q == ST_OK)
		else $error("match reported with bad status");

endmodule
